>>> hw/rtl/bankers_safety_check_unit_assert.svh
// Assertion macros for the safety check unit modules.
// No dependencies; included by modules that carry assertions.
`ifndef BANKERS_SAFETY_CHECK_UNIT_ASSERT_SVH
`define BANKERS_SAFETY_CHECK_UNIT_ASSERT_SVH

// Check a property that holds whenever reset is released.
`define BSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check an implication to the next cycle.
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/bsc_pkg.sv
// Shared types, action codes and controller states for the safety check unit.
// No dependencies.
package bsc_pkg;

	typedef enum logic [1:0] {
		ACT_MAX   = 2'd0,
		ACT_ALLOC = 2'd1,
		ACT_AVAIL = 2'd2,
		ACT_CHECK = 2'd3
	} action_t;

	localparam logic CFG_PROC = 1'b0;
	localparam logic CFG_RES  = 1'b1;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  proc_index;
		logic [2:0]  res_index;
		logic [15:0] value;
	} in_item_t;

	typedef struct packed {
		logic       is_verdict;
		logic [3:0] proc_id;
		logic       safe;
		logic       last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CLEAR,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_NEXT_PROC,
		ST_EMIT,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_VERDICT
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic clear;
		logic scan_start;
		logic scan_read;
		logic scan_cmp;
		logic next_proc;
		logic add_start;
		logic add_read;
		logic add_write;
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic res_last;
		logic proc_last;
		logic fail;
		logic all_done;
		logic is_done;
	} dp_sts_t;

endpackage

>>> hw/rtl/bsc_datapath.sv
// Datapath: claim/allocation memories, available vector, done marks, counters.
// Depends on bsc_pkg.
module bsc_datapath
	import bsc_pkg::*;
#(
	parameter int MAX_PROCS   = 16,
	parameter int MAX_RES     = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	input  in_item_t             item,
	input  logic [4:0]           process_count_q,
	input  logic [3:0]           resource_count_q,
	output dp_sts_t              sts,
	output logic [3:0]           proc_id,
	output logic                 safe
);
	localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int RW = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
	localparam int AW = PW + RW;
	localparam int DEPTH = 1 << AW;
	localparam int NPW = $clog2(MAX_PROCS + 1);
	localparam int NRW = $clog2(MAX_RES + 1);
	localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] max_mem [DEPTH];
	logic [COUNT_WIDTH-1:0] alloc_mem [DEPTH];
	logic [COUNT_WIDTH-1:0] avail_q [MAX_RES];
	logic [MAX_PROCS-1:0]   done_q;
	logic [NPW-1:0]         fin_q;
	logic [PW-1:0]          p_q;
	logic [RW-1:0]          r_q;
	logic [COUNT_WIDTH-1:0] max_rd_q, alloc_rd_q;
	logic                   fail_q;
	logic [NPW-1:0]         np;
	logic [NRW-1:0]         nr;
	logic [AW-1:0]          rd_addr, wr_addr;
	logic [COUNT_WIDTH-1:0] need, wval;
	logic [COUNT_WIDTH:0]   sum;
	logic                   wr_ok;

	// Clamp the counts to 1..table size.
	always_comb begin
		np = (process_count_q == 5'd0) ? NPW'(1) :
			((32'(process_count_q) > MAX_PROCS) ? NPW'(MAX_PROCS) : NPW'(process_count_q));
		nr = (resource_count_q == 4'd0) ? NRW'(1) :
			((32'(resource_count_q) > MAX_RES) ? NRW'(MAX_RES) : NRW'(resource_count_q));
	end

	assign rd_addr = {p_q, r_q};
	assign wr_addr = {PW'(item.proc_index), RW'(item.res_index)};
	assign wval    = COUNT_WIDTH'(item.value & 16'((33'd1 << COUNT_WIDTH) - 33'd1));
	assign wr_ok   = (32'(item.res_index) < MAX_RES) && (32'(item.proc_index) < MAX_PROCS);
	assign need    = (max_rd_q > alloc_rd_q) ? (max_rd_q - alloc_rd_q) : '0;
	assign sum     = {1'b0, avail_q[r_q]} + {1'b0, alloc_rd_q};

	// Table memories: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.load && wr_ok && item.action == ACT_MAX) max_mem[wr_addr] <= wval;
		else if (cmd.add_write) max_mem[rd_addr] <= '0;
		if (cmd.load && wr_ok && item.action == ACT_ALLOC) alloc_mem[wr_addr] <= wval;
		else if (cmd.add_write) alloc_mem[rd_addr] <= '0;
		if (cmd.scan_read || cmd.add_read) begin
			max_rd_q   <= max_mem[rd_addr];
			alloc_rd_q <= alloc_mem[rd_addr];
		end
	end

	// Available vector: load writes and saturating adds.
	always_ff @(posedge clk) begin
		if (cmd.load && item.action == ACT_AVAIL && 32'(item.res_index) < MAX_RES)
			avail_q[RW'(item.res_index)] <= wval;
		else if (cmd.add_write)
			avail_q[r_q] <= sum[COUNT_WIDTH] ? CMAX : sum[COUNT_WIDTH-1:0];
	end

	// Index counters, done marks and fit flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			fin_q  <= '0;
			p_q    <= '0;
			r_q    <= '0;
			fail_q <= 1'b0;
		end else begin
			// Clear marks at check start, mark a process as it finishes.
			if (cmd.clear) begin
				done_q <= '0;
				fin_q  <= '0;
			end else if (cmd.add_start) begin
				done_q[p_q] <= 1'b1;
				fin_q       <= fin_q + NPW'(1);
			end
			// Restart the process scan at zero, or advance past a process that does not fit or is done.
			if (cmd.clear) p_q <= '0;
			else if (cmd.next_proc) p_q <= p_q + PW'(1);
			else if (cmd.scan_start) p_q <= '0;
			// Restart or advance the resource index.
			if (cmd.scan_start || cmd.add_start) r_q <= '0;
			else if (cmd.scan_cmp || cmd.add_write) r_q <= r_q + RW'(1);
			// Track whether any resource failed to fit.
			if (cmd.scan_start || cmd.add_start) fail_q <= 1'b0;
			else if (cmd.scan_cmp && need > avail_q[r_q]) fail_q <= 1'b1;
		end
	end

	assign sts.res_last  = (32'(r_q) + 1 >= 32'(nr));
	assign sts.proc_last = (32'(p_q) + 1 >= 32'(np));
	assign sts.fail      = fail_q;
	assign sts.all_done  = (fin_q >= np);
	assign sts.is_done   = done_q[p_q];
	assign proc_id       = 4'(p_q);
	assign safe          = (fin_q >= np);
endmodule

>>> hw/rtl/bsc_ctrl.sv
// Controller state machine sequencing loads, scan rounds, updates and verdict.
// Depends on bsc_pkg and the assertion macro header.
`include "bankers_safety_check_unit_assert.svh"
module bsc_ctrl
	import bsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  action_t   action,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      out_verdict,
	output dp_cmd_t   cmd,
	input  dp_sts_t   sts
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		out_verdict = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (action == ACT_CHECK) begin
						cmd.clear      = 1'b1;
						cmd.scan_start = 1'b1;
						state_d        = ST_CLEAR;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_LOAD: state_d = ST_IDLE;
			ST_CLEAR: begin
				if (sts.all_done) state_d = ST_VERDICT;
				else if (sts.is_done) state_d = ST_NEXT_PROC;
				else begin
					cmd.scan_read = 1'b1;
					state_d = ST_SCAN_CMP;
				end
			end
			ST_SCAN_RD: begin
				cmd.scan_read = 1'b1;
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				if (sts.res_last) state_d = ST_EMIT;
				else state_d = ST_SCAN_RD;
			end
			ST_EMIT: begin
				// Fit flag now final for this process.
				if (sts.fail) state_d = ST_NEXT_PROC;
				else begin
					out_valid = 1'b1;
					if (out_ready) begin
						cmd.add_start = 1'b1;
						state_d = ST_ADD_RD;
					end
				end
			end
			ST_NEXT_PROC: begin
				if (sts.proc_last) state_d = ST_VERDICT;
				else begin
					cmd.next_proc = 1'b1;
					cmd.scan_start = 1'b1;
					state_d = ST_CLEAR;
				end
			end
			ST_ADD_RD: begin
				cmd.add_read = 1'b1;
				state_d = ST_ADD_WR;
			end
			ST_ADD_WR: begin
				cmd.add_write = 1'b1;
				if (sts.res_last) begin
					cmd.clear = 1'b0;
					cmd.scan_start = 1'b1;
					state_d = ST_CLEAR;
				end else state_d = ST_ADD_RD;
			end
			ST_VERDICT: begin
				out_valid = 1'b1;
				out_verdict = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`BSC_ASSERT(a_no_in_busy, !(in_ready && out_valid), "input taken while result pending")
	`BSC_ASSERT_NEXT(a_verdict_ends, out_valid && out_verdict && out_ready, state_q == ST_IDLE,
		"verdict did not end check")
	`BSC_ASSERT_NEXT(a_emit_adds, state_q == ST_EMIT && out_valid && out_ready,
		state_q == ST_ADD_RD, "emitted process not folded into available")
endmodule

>>> hw/rtl/bankers_safety_check_unit.sv
// A load is taken while idle; a check reads and compares one table entry at a time for each
// unfinished process, skips done processes, emits and folds each process that fits back into
// the available vector and then gives the verdict; result stalls can hold it up.
// One item at a time; results stream out before the next item is taken.
// Reset (arst_n low): counts return to 1, done marks and counters clear; tables stay.
// Top level: configuration registers, controller and datapath. Depends on bsc_pkg.
module bankers_safety_check_unit
	import bsc_pkg::*;
#(
	parameter int MAX_PROCS   = 16,
	parameter int MAX_RES     = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_index,
	input  logic [4:0] cfg_data
);
	logic [4:0] process_count_q;
	logic [3:0] resource_count_q;
	dp_cmd_t    cmd;
	dp_sts_t    sts;
	logic [3:0] pid;
	logic       safe_w, verdict;

	assign cfg_ready = 1'b1;

	// Write configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_count_q  <= 5'd1;
			resource_count_q <= 4'd1;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_PROC) process_count_q <= cfg_data;
			else resource_count_q <= cfg_data[3:0];
		end
	end

	bsc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready,
		.action(action_t'(in_data.action)),
		.out_valid, .out_ready, .out_verdict(verdict), .cmd, .sts
	);

	bsc_datapath #(.MAX_PROCS(MAX_PROCS), .MAX_RES(MAX_RES), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
		.clk, .arst_n, .cmd, .item(in_data), .process_count_q, .resource_count_q,
		.sts, .proc_id(pid), .safe(safe_w)
	);

	// Form the result transfer.
	assign out_data.is_verdict = verdict;
	assign out_data.proc_id    = verdict ? 4'd0 : pid;
	assign out_data.safe       = verdict & safe_w;
	assign out_data.last       = verdict;
endmodule

>>> sim/bankers_safety_check_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the safety check unit: watches the channels, predicts results, compares.
// Depends on bsc_pkg.
module bankers_safety_check_checker
	import bsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  logic      cfg_index,
	input  logic [4:0] cfg_data,
	output int        fail_count,
	output int        pending,
	output int        seq_count,
	output int        safe_count
);

	localparam int NPROC = 16;
	localparam int NRES  = 8;

	logic [15:0] claim_tbl [NPROC][NRES];
	logic [15:0] alloc_tbl [NPROC][NRES];
	logic [15:0] avail_vec [NRES];
	logic [4:0]  procs_reg;
	logic [3:0]  res_reg;
	out_item_t   expected_q [$];

	assign pending = expected_q.size();

	task automatic report(input string what, input logic [3:0] got, input logic [3:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Run the safety rounds on the shadow tables and queue each emitted result.
	task automatic run_safety_rounds();
		int np, nr, finished, p, j, pick;
		logic [NPROC-1:0] done;
		logic [15:0] need;
		logic [16:0] sum;
		bit ok;
		out_item_t r;
		np = (procs_reg == 0) ? 1 : (procs_reg > NPROC ? NPROC : procs_reg);
		nr = (res_reg == 0) ? 1 : (res_reg > NRES ? NRES : res_reg);
		done = '0;
		finished = 0;
		while (finished < np) begin
			pick = -1;
			for (p = 0; p < np && pick < 0; p++) begin
				if (!done[p]) begin
					ok = 1;
					for (j = 0; j < nr; j++) begin
						need = (claim_tbl[p][j] > alloc_tbl[p][j]) ?
							claim_tbl[p][j] - alloc_tbl[p][j] : 16'd0;
						if (need > avail_vec[j]) ok = 0;
					end
					if (ok) pick = p;
				end
			end
			if (pick < 0) break;
			r = '{is_verdict: 1'b0, proc_id: pick[3:0], safe: 1'b0, last: 1'b0};
			expected_q.push_back(r);
			// Release the allocation back to the pool, saturating.
			for (j = 0; j < nr; j++) begin
				sum = avail_vec[j] + alloc_tbl[pick][j];
				avail_vec[j] = sum[16] ? 16'hFFFF : sum[15:0];
				alloc_tbl[pick][j] = '0;
				claim_tbl[pick][j] = '0;
			end
			done[pick] = 1'b1;
			finished++;
		end
		r = '{is_verdict: 1'b1, proc_id: 4'd0, safe: (finished == np), last: 1'b1};
		if (finished == np) safe_count++;
		expected_q.push_back(r);
	endtask

	initial begin
		fail_count = 0;
		seq_count  = 0;
		safe_count = 0;
		foreach (claim_tbl[p, j]) begin
			claim_tbl[p][j] = '0;
			alloc_tbl[p][j] = '0;
		end
		foreach (avail_vec[j]) avail_vec[j] = '0;
	end

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			procs_reg <= 5'd1;
			res_reg   <= 4'd1;
		end else begin
			// Track register writes.
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_PROC) procs_reg <= cfg_data;
				else res_reg <= cfg_data[3:0];
			end
			// Predict on each input transfer.
			if (in_valid && in_ready) begin
				case (in_data.action)
					ACT_MAX:   claim_tbl[in_data.proc_index][in_data.res_index] = in_data.value;
					ACT_ALLOC: alloc_tbl[in_data.proc_index][in_data.res_index] = in_data.value;
					ACT_AVAIL: avail_vec[in_data.res_index] = in_data.value;
					default:   run_safety_rounds();
				endcase
			end
			// Compare each output transfer with the oldest expectation.
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report("result with nothing expected", out_data.proc_id, 4'd0);
				end else begin
					want = expected_q.pop_front();
					if (!want.is_verdict) seq_count++;
					if (out_data.is_verdict !== want.is_verdict)
						report("is_verdict", 4'(out_data.is_verdict), 4'(want.is_verdict));
					if (out_data.proc_id !== want.proc_id)
						report("proc_id", out_data.proc_id, want.proc_id);
					if (out_data.safe !== want.safe)
						report("safe", 4'(out_data.safe), 4'(want.safe));
					if (out_data.last !== want.last)
						report("last", 4'(out_data.last), 4'(want.last));
				end
			end
		end
	end

endmodule

>>> sim/tb_bankers_safety_check_unit.sv
`timescale 1ns / 1ps
// Testbench top for the safety check unit: clock, reset, stimulus and verdict.
// Depends on bsc_pkg, bankers_safety_check_unit and bankers_safety_check_checker.
module tb_bankers_safety_check_unit;
	import bsc_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic      cfg_index;
	logic [4:0] cfg_data;
	int        fail_count, pending, seq_count, safe_count;
	int        item_count, check_count, cfg_count;
	bit        burst_mode;

	bankers_safety_check_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bankers_safety_check_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending),
		.seq_count(seq_count), .safe_count(safe_count)
	);

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	function automatic int draw_gap();
		return burst_mode ? 0 : $urandom_range(0, 9);
	endfunction

	// Send one item; valid stays high afterwards so a back-to-back item needs no toggle.
	task automatic send(input logic [1:0] act, input logic [3:0] p, input logic [2:0] r,
			input logic [15:0] v);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data  <= '{action: act, proc_index: p, res_index: r, value: v};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		item_count++;
		if (act == ACT_CHECK) check_count++;
	endtask

	// Write a register once the unit has drained.
	task automatic cfg_write(input logic idx, input logic [4:0] val);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_count++;
	endtask

	// Result side: stall a random number of cycles before each transfer.
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = draw_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Alternate between stretches with and without idling.
	initial begin
		burst_mode = 0;
		forever begin
			repeat ($urandom_range(100, 600)) @(negedge clk);
			burst_mode = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [4:0] proc_set [6];
		logic [4:0] res_set [6];
		int k, n, roll;
		logic [15:0] v;
		proc_set = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd12};
		res_set  = '{5'd8, 5'd1, 5'd0, 5'd15, 5'd3, 5'd6};
		item_count = 0; check_count = 0; cfg_count = 0;
		in_valid = 1'b0; in_data = '0;
		cfg_valid = 1'b0; cfg_index = CFG_PROC; cfg_data = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill every table entry so no check reads an unwritten one.
		for (int p = 0; p < 16; p++) begin
			for (int r = 0; r < 8; r++) begin
				send(ACT_MAX, 4'(p), 3'(r), 16'($urandom_range(0, 6)));
				send(ACT_ALLOC, 4'(p), 3'(r), 16'($urandom_range(0, 3)));
			end
		end
		for (int r = 0; r < 8; r++) send(ACT_AVAIL, 4'd0, 3'(r), 16'($urandom_range(2, 8)));

		// Directed: reset config check, full size, extremes, saturation, zeroed rows.
		send(ACT_CHECK, 4'd0, 3'd0, 16'd0);
		cfg_write(CFG_PROC, 5'd16);
		cfg_write(CFG_RES, 5'd8);
		send(ACT_MAX, 4'd15, 3'd7, 16'hFFFF);
		send(ACT_ALLOC, 4'd15, 3'd7, 16'hFFFF);
		send(ACT_ALLOC, 4'd0, 3'd0, 16'hAAAA);
		send(ACT_MAX, 4'd0, 3'd0, 16'h5555);
		send(ACT_AVAIL, 4'd0, 3'd0, 16'hFFF0);
		send(ACT_CHECK, 4'd0, 3'd0, 16'd0);
		send(ACT_CHECK, 4'd0, 3'd0, 16'd0);
		send(ACT_MAX, 4'd3, 3'd2, 16'hFFFF);
		send(ACT_AVAIL, 4'd0, 3'd2, 16'h0000);
		send(ACT_CHECK, 4'd0, 3'd0, 16'd0);
		send(ACT_ALLOC, 4'd3, 3'd2, 16'h8000);
		send(ACT_MAX, 4'd3, 3'd2, 16'h0001);
		send(ACT_CHECK, 4'd0, 3'd0, 16'd0);

		// Random phases over several register settings.
		for (k = 0; k < 6; k++) begin
			cfg_write(CFG_PROC, (k == 5) ? 5'($urandom_range(0, 31)) : proc_set[k]);
			cfg_write(CFG_RES, (k == 5) ? 5'($urandom_range(0, 15)) : res_set[k]);
			for (n = 0; n < 8; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 15) v = 16'($urandom);
				else if (roll < 75) v = 16'($urandom_range(0, 8));
				else v = 16'($urandom_range(0, 400));
				roll = $urandom_range(0, 99);
				if (roll < 20) send(ACT_CHECK, 4'($urandom), 3'($urandom), 16'($urandom));
				else if (roll < 45) send(ACT_AVAIL, 4'($urandom), 3'($urandom), v);
				else if (roll < 75) send(ACT_MAX, 4'($urandom), 3'($urandom), v);
				else send(ACT_ALLOC, 4'($urandom), 3'($urandom), v);
			end
			send(ACT_CHECK, 4'd0, 3'd0, 16'd0);
		end
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("covered %0d items with %0d checks over %0d register writes", item_count,
			check_count, cfg_count);
		$display("saw %0d finished processes and %0d safe verdicts", seq_count, safe_count);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
